[hw/rtl/assert_macros.svh]
// assertion macros for the rtl files
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

[hw/rtl/bmp_pkg.sv]
// types, codes and constants of the bmp 32 bpp stream decoder
// no dependencies
package bmp_pkg;

	localparam int unsigned MAX_DIMENSION = 16384;
	localparam int DIM_W = $clog2(MAX_DIMENSION + 1);

	localparam int W_BYTE = 8;
	localparam int W_KIND = 2;
	localparam int W_CODE = 4;
	localparam int W_IMG = 15;
	localparam int W_ARGB = 32;
	localparam int W_POS = 14;

	localparam int CNT_W = (DIM_W > W_POS) ? DIM_W : W_POS;
	localparam int PROD_W = 2 * DIM_W;
	localparam int EXT_W = ((PROD_W + 2 > 32) ? PROD_W + 2 : 32) + 1;

	localparam logic [31:0] MAX_DIM_32 = 32'(MAX_DIMENSION);
	localparam logic [31:0] LEN_MIN = 32'd54;
	localparam logic [31:0] DIB_MIN = 32'd40;
	localparam logic [32:0] FILE_HDR_LEN = 33'd14;
	localparam logic [31:0] MIN_OFFSET = 32'd34;
	localparam logic [31:0] HEIGHT_INVALID = 32'h8000_0000;
	localparam logic [15:0] BPP_32 = 16'd32;
	localparam logic [15:0] SIG_BM = 16'h4D42;

	localparam logic [31:0] IDX_SIG = 32'd1;
	localparam logic [31:0] IDX_SIZE = 32'd5;
	localparam logic [31:0] IDX_OFFSET = 32'd13;
	localparam logic [31:0] IDX_DIB = 32'd17;
	localparam logic [31:0] IDX_WIDTH = 32'd21;
	localparam logic [31:0] IDX_HEIGHT = 32'd25;
	localparam logic [31:0] IDX_BPP = 32'd29;
	localparam logic [31:0] IDX_COMP = 32'd33;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HEADER,
		PH_PIXELS,
		PH_DONE
	} phase_t;

	typedef enum logic [W_KIND-1:0] {
		KIND_HEADER = 2'd0,
		KIND_PIXEL = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic [W_CODE-1:0] {
		ERR_NONE = 4'd0,
		ERR_SHORT = 4'd1,
		ERR_SIG = 4'd2,
		ERR_SIZE = 4'd3,
		ERR_DIB_SMALL = 4'd4,
		ERR_DIB_OVER = 4'd5,
		ERR_WIDTH = 4'd6,
		ERR_FORMAT = 4'd7,
		ERR_HEIGHT = 4'd8,
		ERR_EXTENT = 4'd9
	} err_t;

	typedef struct packed {
		kind_t kind;
		err_t code;
		logic [W_IMG-1:0] width;
		logic [W_IMG-1:0] height;
		logic [W_ARGB-1:0] argb;
		logic [W_POS-1:0] column;
		logic [W_POS-1:0] row;
		logic last;
	} result_t;

endpackage

[hw/rtl/bmp_if.sv]
// stream interfaces of the bmp decoder: file bytes in, results out
// depends on bmp_pkg
interface bmp_byte_if import bmp_pkg::*; ();
	logic valid;
	logic ready;
	logic [W_BYTE-1:0] byte_value;
	logic start_of_file;

	modport source (output valid, output byte_value, output start_of_file, input ready);
	modport sink (input valid, input byte_value, input start_of_file, output ready);
endinterface

interface bmp_result_if import bmp_pkg::*; ();
	logic valid;
	logic ready;
	logic [W_KIND-1:0] result_kind;
	logic [W_CODE-1:0] error_code;
	logic [W_IMG-1:0] image_width;
	logic [W_IMG-1:0] image_height;
	logic [W_ARGB-1:0] pixel_argb;
	logic [W_POS-1:0] pixel_column;
	logic [W_POS-1:0] pixel_row;
	logic last_pixel;

	modport source (output valid, output result_kind, output error_code, output image_width,
		output image_height, output pixel_argb, output pixel_column, output pixel_row,
		output last_pixel, input ready);
	modport sink (input valid, input result_kind, input error_code, input image_width,
		input image_height, input pixel_argb, input pixel_column, input pixel_row,
		input last_pixel, output ready);
endinterface

[hw/rtl/bmp32_stream_decoder_top.sv]
// top level of the bmp 32 bpp bi_rgb stream decoder
// depends on bmp_pkg, bmp_if and assert_macros.svh
//
// The decoder takes one file byte per clock cycle, a byte with start_of_file set
// opening a new file, and gives at most one result per byte. All per-byte work
// (field capture, the header checks at byte 33, pixel assembly and the column and
// row counters) is combinational per byte; results go through a two-entry output
// buffer, so bytes keep flowing while one result waits and the input stalls only
// once both entries are full. The extent product is registered in the cycle after
// the height field lands, well before the checks need it. Write file_length only
// between files (unenforced); it is sampled at byte 33. No clearing pass after reset.
`include "assert_macros.svh"

module bmp32_stream_decoder_top import bmp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [31:0] cfg_wdata,
	bmp_byte_if.sink byte_ch,
	bmp_result_if.source result_ch
);

	phase_t phase_q, phase_d, phase_c;
	logic [31:0] bc_q, bc_d, bc_c;
	logic [31:0] hs_q, hs_d, hs_c, hs_new;
	logic [15:0] sig_q, sig_d;
	logic [31:0] size_q, size_d;
	logic [31:0] offset_q, offset_d;
	logic [31:0] dib_q, dib_d;
	logic [31:0] width_q, width_d;
	logic [31:0] height_q, height_d;
	logic [31:0] abs_h_q, abs_h_d;
	logic [15:0] bpp_q, bpp_d;
	logic [23:0] held_q, held_d;
	logic [CNT_W-1:0] col_q, col_d, col_c;
	logic [CNT_W-1:0] row_q, row_d, row_c;
	logic [CNT_W-1:0] dst_row;
	logic [PROD_W-1:0] prod_q;
	logic [31:0] file_length_q;
	logic [31:0] fs_c;
	logic [EXT_W-1:0] ext_c;
	logic [1:0] k_c;
	logic col_last, row_last, last_c;
	err_t err_c;
	result_t res;
	logic res_valid;

	result_t slot_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic acc, push, pop;

	assign acc = byte_ch.valid && byte_ch.ready;
	assign push = acc && res_valid;
	assign pop = result_ch.valid && result_ch.ready;
	assign byte_ch.ready = (count_q != 2'd2);

	// restart on start_of_file
	assign phase_c = byte_ch.start_of_file ? PH_HEADER : phase_q;
	assign bc_c = byte_ch.start_of_file ? 32'd0 : bc_q;
	assign hs_c = byte_ch.start_of_file ? 32'd0 : hs_q;
	assign col_c = byte_ch.start_of_file ? '0 : col_q;
	assign row_c = byte_ch.start_of_file ? '0 : row_q;
	assign hs_new = {byte_ch.byte_value, hs_c[31:8]};

	// header checks, in priority order
	assign fs_c = (file_length_q != 32'd0) ? file_length_q : size_q;
	assign ext_c = EXT_W'(offset_q) + EXT_W'({prod_q, 2'b00});

	always_comb begin
		if (file_length_q != 32'd0 && file_length_q < LEN_MIN) begin
			err_c = ERR_SHORT;
		end else if (sig_q != SIG_BM) begin
			err_c = ERR_SIG;
		end else if (fs_c != 32'd0 && size_q > fs_c) begin
			err_c = ERR_SIZE;
		end else if (dib_q < DIB_MIN) begin
			err_c = ERR_DIB_SMALL;
		end else if (fs_c != 32'd0 && ({1'b0, dib_q} + FILE_HDR_LEN) > {1'b0, fs_c}) begin
			err_c = ERR_DIB_OVER;
		end else if (width_q == 32'd0 || width_q > MAX_DIM_32) begin
			err_c = ERR_WIDTH;
		end else if (bpp_q != BPP_32 || hs_new != 32'd0) begin
			err_c = ERR_FORMAT;
		end else if (height_q == HEIGHT_INVALID || abs_h_q == 32'd0 || abs_h_q > MAX_DIM_32) begin
			err_c = ERR_HEIGHT;
		end else if (offset_q < MIN_OFFSET || offset_q > fs_c || ext_c > EXT_W'(fs_c)) begin
			err_c = ERR_EXTENT;
		end else begin
			err_c = ERR_NONE;
		end
	end

	// pixel position
	assign k_c = bc_c[1:0] - offset_q[1:0];
	assign col_last = ({1'b0, col_c} + (CNT_W + 1)'(1)) >= {1'b0, width_q[CNT_W-1:0]};
	assign row_last = ({1'b0, row_c} + (CNT_W + 1)'(1)) >= {1'b0, abs_h_q[CNT_W-1:0]};
	assign last_c = col_last && row_last;
	assign dst_row = height_q[31] ? row_c : (abs_h_q[CNT_W-1:0] - CNT_W'(1) - row_c);

	always_comb begin
		phase_d = phase_q;
		bc_d = bc_q;
		hs_d = hs_q;
		sig_d = sig_q;
		size_d = size_q;
		offset_d = offset_q;
		dib_d = dib_q;
		width_d = width_q;
		height_d = height_q;
		abs_h_d = abs_h_q;
		bpp_d = bpp_q;
		held_d = held_q;
		col_d = col_q;
		row_d = row_q;
		res = '0;
		res_valid = 1'b0;
		if (acc) begin
			phase_d = phase_c;
			bc_d = bc_c;
			hs_d = hs_c;
			col_d = col_c;
			row_d = row_c;
			unique case (phase_c)
				PH_HEADER: begin
					bc_d = (bc_c == 32'hFFFF_FFFF) ? bc_c : bc_c + 32'd1;
					hs_d = hs_new;
					unique case (bc_c)
						IDX_SIG: sig_d = hs_new[31:16];
						IDX_SIZE: size_d = hs_new;
						IDX_OFFSET: offset_d = hs_new;
						IDX_DIB: dib_d = hs_new;
						IDX_WIDTH: width_d = hs_new;
						IDX_HEIGHT: begin
							height_d = hs_new;
							abs_h_d = hs_new[31] ? (32'd0 - hs_new) : hs_new;
						end
						IDX_BPP: bpp_d = hs_new[31:16];
						IDX_COMP: begin
							res_valid = 1'b1;
							if (err_c != ERR_NONE) begin
								phase_d = PH_DONE;
								res.kind = KIND_ERROR;
								res.code = err_c;
							end else begin
								phase_d = PH_PIXELS;
								res.kind = KIND_HEADER;
								res.width = width_q[W_IMG-1:0];
								res.height = abs_h_q[W_IMG-1:0];
							end
						end
						default: begin
						end
					endcase
				end
				PH_PIXELS: begin
					bc_d = (bc_c == 32'hFFFF_FFFF) ? bc_c : bc_c + 32'd1;
					if (bc_c >= offset_q) begin
						unique case (k_c)
							2'd0: held_d[7:0] = byte_ch.byte_value;
							2'd1: held_d[15:8] = byte_ch.byte_value;
							2'd2: held_d[23:16] = byte_ch.byte_value;
							2'd3: begin
								res_valid = 1'b1;
								res.kind = KIND_PIXEL;
								res.argb = {byte_ch.byte_value, held_q};
								res.column = col_c[W_POS-1:0];
								res.row = dst_row[W_POS-1:0];
								res.last = last_c;
								if (col_last) begin
									col_d = '0;
									row_d = row_c + CNT_W'(1);
								end else begin
									col_d = col_c + CNT_W'(1);
								end
								if (last_c) begin
									phase_d = PH_DONE;
								end
							end
							default: begin
							end
						endcase
					end
				end
				PH_IDLE, PH_DONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bc_q <= 32'd0;
			col_q <= '0;
			row_q <= '0;
			file_length_q <= 32'd0;
		end else begin
			phase_q <= phase_d;
			bc_q <= bc_d;
			col_q <= col_d;
			row_q <= row_d;
			if (cfg_we) begin
				file_length_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		hs_q <= hs_d;
		sig_q <= sig_d;
		size_q <= size_d;
		offset_q <= offset_d;
		dib_q <= dib_d;
		width_q <= width_d;
		height_q <= height_d;
		abs_h_q <= abs_h_d;
		bpp_q <= bpp_d;
		held_q <= held_d;
		prod_q <= PROD_W'(width_q[DIM_W-1:0]) * PROD_W'(abs_h_q[DIM_W-1:0]);
	end

	// two-entry output buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= res;
		end
	end

	assign result_ch.valid = (count_q != 2'd0);
	assign result_ch.result_kind = slot_q[rd_ptr_q].kind;
	assign result_ch.error_code = slot_q[rd_ptr_q].code;
	assign result_ch.image_width = slot_q[rd_ptr_q].width;
	assign result_ch.image_height = slot_q[rd_ptr_q].height;
	assign result_ch.pixel_argb = slot_q[rd_ptr_q].argb;
	assign result_ch.pixel_column = slot_q[rd_ptr_q].column;
	assign result_ch.pixel_row = slot_q[rd_ptr_q].row;
	assign result_ch.last_pixel = slot_q[rd_ptr_q].last;

	`ASSERT_NEVER(a_no_overflow, push && count_q == 2'd2 && !pop, "result buffer overflow")
	`ASSERT_CLK(a_idle_silent, (acc && !byte_ch.start_of_file && (phase_q == PH_IDLE || phase_q == PH_DONE)) |-> !push, "result outside a file")
	`ASSERT_CLK(a_last_done, (push && res.kind == KIND_PIXEL && res.last) |=> (phase_q == PH_DONE), "no stop after last pixel")

endmodule
